/* rtl/assert_macros.svh */
// Assertion macros for the checker file of this block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The expression must hold at every clock edge outside reset.
`define HCTB_ASSERT(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) expr) else $error(msg);

// The expression must never hold at a clock edge outside reset.
`define HCTB_NEVER(lbl, clk, rst_n, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

/* rtl/hctb_pkg.sv */
// Shared constants and controller/datapath command and status types.
// No dependencies.
package hctb_pkg;

    // Default sizing of the tree and the codes.
    localparam int DEF_MAX_WORDS    = 4096;
    localparam int DEF_MAX_CODE_LEN = 40;
    localparam int DEF_COUNT_BITS   = 40;

    // Widest count the datapath supports.
    localparam int COUNT_BITS_MAX = 48;

    // Fixed port widths.
    localparam int WORD_COUNT_W = 40;
    localparam int WORD_INDEX_W = 12;
    localparam int INNER_NODE_W = 12;
    localparam int DEPTH_W      = 6;

    // Operation codes.
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic rd_issue;
        logic pick;
        logic second;
        logic write_sum;
        logic walk_init;
        logic walk_step;
        logic emit_issue;
    } hctb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic build_go;
        logic query_ok;
        logic last_merge;
        logic walk_end;
        logic emit_last;
    } hctb_status_t;

endpackage

/* rtl/hctb_ctrl.sv */
// Controller state machine for the Huffman tree builder.
// Depends on hctb_pkg.
module hctb_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  operation,
    input  hctb_pkg::hctb_status_t status,
    output hctb_pkg::hctb_cmd_t    cmd,
    output logic                  busy
);
    import hctb_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_RD1    = 4'd1;
    localparam logic [3:0] S_PK1    = 4'd2;
    localparam logic [3:0] S_RD2    = 4'd3;
    localparam logic [3:0] S_PK2    = 4'd4;
    localparam logic [3:0] S_SUM    = 4'd5;
    localparam logic [3:0] S_WALK   = 4'd6;
    localparam logic [3:0] S_EMIT   = 4'd7;
    localparam logic [3:0] S_DRAIN1 = 4'd8;
    localparam logic [3:0] S_DRAIN2 = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    if (operation == OP_LOAD)
                    begin
                        cmd.load = 1'b1;
                        if (status.build_go)
                        begin
                            state_next = S_RD1;
                        end
                    end
                    else if (status.query_ok)
                    begin
                        cmd.walk_init = 1'b1;
                        state_next    = S_WALK;
                    end
                end
            end
            S_RD1:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_PK1;
            end
            S_PK1:
            begin
                cmd.pick   = 1'b1;
                state_next = S_RD2;
            end
            S_RD2:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_PK2;
            end
            S_PK2:
            begin
                cmd.pick   = 1'b1;
                cmd.second = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.write_sum = 1'b1;
                state_next    = status.last_merge ? S_IDLE : S_RD1;
            end
            S_WALK:
            begin
                cmd.walk_step = 1'b1;
                if (status.walk_end)
                begin
                    state_next = S_EMIT;
                end
            end
            S_EMIT:
            begin
                cmd.emit_issue = 1'b1;
                if (status.emit_last)
                begin
                    state_next = S_DRAIN1;
                end
            end
            S_DRAIN1:
            begin
                state_next = S_DRAIN2;
            end
            S_DRAIN2:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign busy = (state_reg != S_IDLE);

endmodule

/* rtl/hctb_datapath.sv */
// Datapath: count, parent and branch memories, merge pointers, walk buffer
// and result registers. Depends on hctb_pkg.
module hctb_datapath #(
    parameter int MAX_WORDS    = hctb_pkg::DEF_MAX_WORDS,
    parameter int MAX_CODE_LEN = hctb_pkg::DEF_MAX_CODE_LEN,
    parameter int COUNT_BITS   = hctb_pkg::DEF_COUNT_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  hctb_pkg::hctb_cmd_t                 cmd,
    output hctb_pkg::hctb_status_t              status,
    input  logic [hctb_pkg::WORD_COUNT_W-1:0]   word_count,
    input  logic [hctb_pkg::WORD_INDEX_W-1:0]   word_index,
    input  logic                                last_word,
    output logic                                code_valid,
    output logic                                code_bit,
    output logic [hctb_pkg::INNER_NODE_W-1:0]   inner_node,
    output logic [hctb_pkg::DEPTH_W-1:0]        depth,
    output logic                                code_end
);
    import hctb_pkg::*;

    localparam int SLOTS = 2 * MAX_WORDS;
    localparam int NW    = $clog2(MAX_WORDS + 1);
    localparam int AW    = $clog2(SLOTS);
    localparam int SW    = $clog2(SLOTS + 1);
    localparam int LW    = $clog2(MAX_CODE_LEN);
    localparam int MW    = $clog2(MAX_CODE_LEN + 1);
    localparam int IW    = 32;

    // Memories.
    logic [COUNT_BITS-1:0] cnt_mem [SLOTS];
    logic [AW-1:0]         par_mem [SLOTS];
    logic                  br_mem  [SLOTS];
    logic [AW:0]           buf_mem [MAX_CODE_LEN];

    // Vocabulary and build state.
    logic [NW-1:0]         words_reg;
    logic                  closed_reg;
    logic                  ready_reg;
    logic [NW-1:0]         lp_reg;
    logic [AW-1:0]         ip_reg;
    logic [AW-1:0]         created_reg;
    logic [NW-1:0]         merges_reg;
    logic [COUNT_BITS-1:0] c1_reg;
    logic [COUNT_BITS-1:0] sum_reg;
    logic [COUNT_BITS-1:0] cnt_ra_reg;
    logic [COUNT_BITS-1:0] cnt_rb_reg;

    // Walk and emission state.
    logic [AW-1:0]         cur_reg;
    logic [AW-1:0]         par_rd_reg;
    logic                  br_rd_reg;
    logic [LW-1:0]         wptr_reg;
    logic [MW-1:0]         i_reg;
    logic [SW-1:0]         steps_reg;
    logic [LW-1:0]         rp_reg;
    logic [LW-1:0]         k_reg;
    logic [MW-1:0]         m_reg;
    logic [AW:0]           buf_rd_reg;
    logic                  rd_v_reg;
    logic [LW-1:0]         rk_reg;
    logic [AW-1:0]         prev_reg;

    // Result registers.
    logic                    strobe_reg;
    logic                    bit_reg;
    logic [INNER_NODE_W-1:0] inner_reg;
    logic [DEPTH_W-1:0]      depth_reg;
    logic                    end_reg;

    // Load bookkeeping.
    logic [COUNT_BITS_MAX-1:0] wc_wide;
    logic [COUNT_BITS-1:0]     cnt_in;
    logic [NW-1:0]             n_base;
    logic                      has_room;
    logic [NW-1:0]             n_new;

    assign wc_wide  = COUNT_BITS_MAX'(word_count);
    assign cnt_in   = wc_wide[COUNT_BITS-1:0];
    assign n_base   = closed_reg ? '0 : words_reg;
    assign has_room = (n_base < NW'(MAX_WORDS));
    assign n_new    = has_room ? n_base + 1'b1 : n_base;

    // Merge choice: with both available, a leaf wins only with a strictly smaller count.
    logic                  leaf_ok;
    logic                  inner_ok;
    logic                  take_leaf;
    logic [AW-1:0]         leaf_addr;
    logic [AW-1:0]         pick_addr;
    logic [COUNT_BITS-1:0] pick_cnt;
    logic [COUNT_BITS:0]   sum_full;

    assign leaf_ok   = (lp_reg != '0);
    assign inner_ok  = (ip_reg < created_reg);
    assign take_leaf = leaf_ok && (!inner_ok || (cnt_ra_reg < cnt_rb_reg));
    assign leaf_addr = AW'(lp_reg - 1'b1);
    assign pick_addr = take_leaf ? leaf_addr : ip_reg;
    assign pick_cnt  = take_leaf ? cnt_ra_reg : cnt_rb_reg;
    assign sum_full  = {1'b0, c1_reg} + {1'b0, pick_cnt};

    // Walk termination and depth counting.
    logic [AW-1:0] root;
    logic [MW-1:0] i_inc;
    logic [SW-1:0] steps_inc;

    assign root      = AW'({words_reg, 1'b0} - 2'd2);
    assign i_inc     = (i_reg < MW'(MAX_CODE_LEN)) ? i_reg + 1'b1 : i_reg;
    assign steps_inc = steps_reg + 1'b1;

    // Status to the controller.
    always_comb
    begin
        status.build_go   = last_word && (n_new >= NW'(2));
        status.query_ok   = ready_reg && (IW'(word_index) < IW'(words_reg));
        status.last_merge = ((NW + 1)'(merges_reg) + 2'd2 >= (NW + 1)'(words_reg));
        status.walk_end   = (par_rd_reg == root) || (steps_inc >= SW'(SLOTS));
        status.emit_last  = (MW'(k_reg) + 1'b1 == m_reg);
    end

    // Count memory: written by loads and merges, two registered read ports.
    logic                  cnt_we;
    logic [AW-1:0]         cnt_wa;
    logic [COUNT_BITS-1:0] cnt_wd;

    always_comb
    begin
        cnt_we = 1'b0;
        cnt_wa = created_reg;
        cnt_wd = sum_reg;
        if (cmd.load && has_room)
        begin
            cnt_we = 1'b1;
            cnt_wa = AW'(n_base);
            cnt_wd = cnt_in;
        end
        else if (cmd.write_sum)
        begin
            cnt_we = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_wa] <= cnt_wd;
        end
        if (cmd.rd_issue)
        begin
            cnt_ra_reg <= cnt_mem[leaf_addr];
            cnt_rb_reg <= cnt_mem[ip_reg];
        end
    end

    // Parent and branch memories: written at each pick, read along the walk.
    logic [AW-1:0] walk_addr;

    assign walk_addr = cmd.walk_init ? AW'(word_index) : par_rd_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.pick)
        begin
            par_mem[pick_addr] <= created_reg;
            br_mem[pick_addr]  <= cmd.second;
        end
        if (cmd.walk_init || (cmd.walk_step && !status.walk_end))
        begin
            par_rd_reg <= par_mem[walk_addr];
            br_rd_reg  <= br_mem[walk_addr];
        end
    end

    // Walk buffer: leaf-to-root path with branch bits, read back root first.
    always_ff @(posedge clk)
    begin
        if (cmd.walk_step)
        begin
            buf_mem[wptr_reg] <= {br_rd_reg, cur_reg};
        end
        if (cmd.emit_issue)
        begin
            buf_rd_reg <= buf_mem[rp_reg];
        end
    end

    // Control registers of load, build, walk and emission.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            words_reg   <= '0;
            closed_reg  <= 1'b0;
            ready_reg   <= 1'b0;
            lp_reg      <= '0;
            ip_reg      <= '0;
            created_reg <= '0;
            merges_reg  <= '0;
            wptr_reg    <= '0;
            i_reg       <= '0;
            steps_reg   <= '0;
            rp_reg      <= '0;
            k_reg       <= '0;
            m_reg       <= '0;
            rd_v_reg    <= 1'b0;
            strobe_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                words_reg   <= n_new;
                closed_reg  <= last_word;
                ready_reg   <= 1'b0;
                lp_reg      <= n_new;
                ip_reg      <= AW'(n_new);
                created_reg <= AW'(n_new);
                merges_reg  <= '0;
            end
            if (cmd.pick)
            begin
                if (take_leaf)
                begin
                    lp_reg <= lp_reg - 1'b1;
                end
                else
                begin
                    ip_reg <= ip_reg + 1'b1;
                end
            end
            if (cmd.write_sum)
            begin
                created_reg <= created_reg + 1'b1;
                merges_reg  <= merges_reg + 1'b1;
                if (status.last_merge)
                begin
                    ready_reg <= 1'b1;
                end
            end
            if (cmd.walk_init)
            begin
                wptr_reg  <= '0;
                i_reg     <= '0;
                steps_reg <= '0;
            end
            if (cmd.walk_step)
            begin
                wptr_reg  <= (wptr_reg == LW'(MAX_CODE_LEN - 1)) ? '0 : wptr_reg + 1'b1;
                i_reg     <= i_inc;
                steps_reg <= steps_inc;
                if (status.walk_end)
                begin
                    rp_reg <= wptr_reg;
                    k_reg  <= '0;
                    m_reg  <= i_inc;
                end
            end
            if (cmd.emit_issue)
            begin
                k_reg  <= k_reg + 1'b1;
                rp_reg <= (rp_reg == '0) ? LW'(MAX_CODE_LEN - 1) : rp_reg - 1'b1;
            end
            rd_v_reg   <= cmd.emit_issue;
            strobe_reg <= rd_v_reg;
        end
    end

    // Payload registers of the build, the walk and the result stage.
    always_ff @(posedge clk)
    begin
        if (cmd.pick && !cmd.second)
        begin
            c1_reg <= pick_cnt;
        end
        if (cmd.pick && cmd.second)
        begin
            sum_reg <= sum_full[COUNT_BITS] ? '1 : sum_full[COUNT_BITS-1:0];
        end
        if (cmd.walk_init)
        begin
            cur_reg <= AW'(word_index);
        end
        else if (cmd.walk_step)
        begin
            cur_reg <= par_rd_reg;
        end
        if (cmd.emit_issue)
        begin
            rk_reg <= k_reg;
        end
        if (rd_v_reg)
        begin
            bit_reg   <= buf_rd_reg[AW];
            inner_reg <= (rk_reg == '0) ? INNER_NODE_W'(words_reg - 2'd2)
                                        : INNER_NODE_W'(prev_reg - AW'(words_reg));
            depth_reg <= DEPTH_W'(rk_reg);
            end_reg   <= (MW'(rk_reg) + 1'b1 == m_reg);
            prev_reg  <= buf_rd_reg[AW-1:0];
        end
    end

    assign code_valid = strobe_reg;
    assign code_bit   = bit_reg;
    assign inner_node = inner_reg;
    assign depth      = depth_reg;
    assign code_end   = end_reg;

endmodule

/* rtl/huffman_code_tree_builder.sv */
// Top level of the Huffman code tree builder: controller plus datapath.
// Depends on hctb_pkg, hctb_ctrl and hctb_datapath.
//
//  channel   handshake            payload
//  request   start & !busy        operation, word_count, word_index, last_word
//  result    code_valid (1 cycle) code_bit, inner_node, depth, code_end
//
// A load is taken while idle; the load marked last then builds the tree when
// at least two words are loaded, each merge reading, picking, reading and
// picking the second node, then writing the sum. A query walks one parent
// link per cycle, then emits one bit per cycle root first; busy stays high
// through S_DRAIN1 and S_DRAIN2 after the last bit, then returns to idle.
// Reset is asynchronous and needs no clearing pass. Results cannot be stalled.
module huffman_code_tree_builder #(
    parameter int MAX_WORDS    = hctb_pkg::DEF_MAX_WORDS,
    parameter int MAX_CODE_LEN = hctb_pkg::DEF_MAX_CODE_LEN,
    parameter int COUNT_BITS   = hctb_pkg::DEF_COUNT_BITS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic                              operation,
    input  logic [hctb_pkg::WORD_COUNT_W-1:0] word_count,
    input  logic [hctb_pkg::WORD_INDEX_W-1:0] word_index,
    input  logic                              last_word,
    output logic                              code_valid,
    output logic                              code_bit,
    output logic [hctb_pkg::INNER_NODE_W-1:0] inner_node,
    output logic [hctb_pkg::DEPTH_W-1:0]      depth,
    output logic                              code_end
);
    import hctb_pkg::*;

    hctb_cmd_t    cmd;
    hctb_status_t status;

    // Sequencing of loads, merges, walks and emission.
    hctb_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .operation (operation),
        .status    (status),
        .cmd       (cmd),
        .busy      (busy)
    );

    // Storage and arithmetic.
    hctb_datapath #(
        .MAX_WORDS    (MAX_WORDS),
        .MAX_CODE_LEN (MAX_CODE_LEN),
        .COUNT_BITS   (COUNT_BITS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .word_count (word_count),
        .word_index (word_index),
        .last_word  (last_word),
        .code_valid (code_valid),
        .code_bit   (code_bit),
        .inner_node (inner_node),
        .depth      (depth),
        .code_end   (code_end)
    );

endmodule

/* rtl/hctb_checker.sv */
// Port-level checker for the Huffman code tree builder, bound to the top.
// Depends on hctb_pkg and assert_macros.svh.
`include "assert_macros.svh"

module hctb_checker (
    input logic                              clk,
    input logic                              rst_n,
    input logic                              busy,
    input logic                              code_valid,
    input logic                              code_end,
    input logic [hctb_pkg::DEPTH_W-1:0]      depth
);
    import hctb_pkg::*;

    // Results only appear while a query is in progress.
    `HCTB_ASSERT(a_valid_busy, clk, rst_n, code_valid |-> busy, "result outside a query")

    // The bits of one code arrive in consecutive cycles.
    `HCTB_ASSERT(a_burst, clk, rst_n, (code_valid && !code_end) |=> code_valid, "gap in code")

    // Depth counts up by one along a code.
    `HCTB_ASSERT(a_depth, clk, rst_n, (code_valid && !code_end) |=> (depth == $past(depth) + 1'b1), "depth skipped")

    // A code ends before the next query can produce anything.
    `HCTB_ASSERT(a_end_gap, clk, rst_n, (code_valid && code_end) |=> !code_valid, "result after code end")

    // The first bit of a code is at depth zero.
    `HCTB_NEVER(a_first, clk, rst_n, code_valid && !$past(code_valid) && (depth != '0), "code starts deep")

endmodule

bind huffman_code_tree_builder hctb_checker u_hctb_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .busy       (busy),
    .code_valid (code_valid),
    .code_end   (code_end),
    .depth      (depth)
);
